[rtl/wpr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpr_pkg
// Shared types and constants of the weighted PageRank iteration block.
// ----------------------------------------------------------------------------
package wpr_pkg;

    localparam int NODE_W   = 5;
    localparam int WEIGHT_W = 16;
    localparam int SCORE_W  = 24;
    localparam int OSUM_W   = 21;
    localparam int CFG_W    = 16;
    localparam int CFGI_W   = 2;
    localparam int DIV_STEPS = 24;

    localparam logic [SCORE_W-1:0] ONE_Q816  = 24'd65536;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 24'hFFFFFF;
    localparam logic [OSUM_W-1:0]  OSUM_MAX  = 21'h1FFFFF;

    typedef enum logic [CFGI_W-1:0] {
        CFG_NODE_COUNT = 2'd0,
        CFG_DAMPING    = 2'd1,
        CFG_TOLERANCE  = 2'd2,
        CFG_MAX_ITER   = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        OP_HOLD,
        OP_INIT,
        OP_SUM,
        OP_MUL,
        OP_DIV,
        OP_LOADT,
        OP_SHIFT,
        OP_UPD,
        OP_COMMIT
    } cell_op_t;

    typedef struct packed {
        cell_op_t             op;
        logic [SCORE_W-1:0]   nv;
    } cell_ctrl_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_SUM_RD,
        S_SUM_ACC,
        S_ITER_START,
        S_RD,
        S_MUL,
        S_DIV,
        S_LOADT,
        S_SHIFT,
        S_MULD,
        S_UPD,
        S_ITER_END,
        S_OUT_LOAD,
        S_OUT_WAIT
    } wpr_state_t;

endpackage

`default_nettype wire

[rtl/wpr_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpr_in_if
// Input channel: one edge-weight matrix element per transfer.
// ----------------------------------------------------------------------------
interface wpr_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  row_index;
    logic [4:0]  col_index;
    logic [15:0] weight;
    logic        last;

    modport source (output valid, output row_index, output col_index,
                    output weight, output last, input ready);
    modport sink   (input valid, input row_index, input col_index,
                    input weight, input last, output ready);
endinterface

`default_nettype wire

[rtl/wpr_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpr_out_if
// Output channel: one node score per transfer.
// ----------------------------------------------------------------------------
interface wpr_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  node_index;
    logic [23:0] score;
    logic        converged;
    logic        last_result;

    modport source (output valid, output node_index, output score,
                    output converged, output last_result, input ready);
    modport sink   (input valid, input node_index, input score,
                    input converged, input last_result, output ready);
endinterface

`default_nettype wire

[rtl/wpr_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpr_mem
// Weight matrix memory: one word per destination column, one lane per source
// row. Lane write or whole-word clear, registered read of a full column.
// ----------------------------------------------------------------------------
module wpr_mem #(
    parameter int MAX_NODES = 32,
    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
    input  wire logic                              clk,
    input  wire logic                              wr_en,
    input  wire logic                              wr_clear,
    input  wire logic [IW-1:0]                     wr_addr,
    input  wire logic [IW-1:0]                     wr_lane,
    input  wire logic [wpr_pkg::WEIGHT_W-1:0]      wr_data,
    input  wire logic [IW-1:0]                     rd_addr,
    output logic [MAX_NODES*wpr_pkg::WEIGHT_W-1:0] rd_data
);
    import wpr_pkg::*;

    logic [MAX_NODES*WEIGHT_W-1:0] mem [MAX_NODES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int l = 0; l < MAX_NODES; l++)
            begin
                if (wr_clear)
                begin
                    mem[wr_addr][l*WEIGHT_W +: WEIGHT_W] <= '0;
                end
                else if (wr_lane == IW'(l))
                begin
                    mem[wr_addr][l*WEIGHT_W +: WEIGHT_W] <= wr_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/wpr_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpr_cell
// One node of the chain: score, next score, out-sum, a bit-serial divider for
// its weighted term, and a term register that shifts toward the chain tail.
// ----------------------------------------------------------------------------
module wpr_cell #(
    parameter int MAX_NODES = 32,
    parameter int CELL_ID   = 0,
    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
    localparam int CW = $clog2(MAX_NODES + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire wpr_pkg::cell_ctrl_t           ctrl,
    input  wire logic [IW-1:0]                 idx,
    input  wire logic [CW-1:0]                 n,
    input  wire logic [wpr_pkg::WEIGHT_W-1:0]  lane_w,
    input  wire logic [wpr_pkg::SCORE_W-1:0]   prev_term,
    output logic [wpr_pkg::SCORE_W-1:0]        term,
    output logic [wpr_pkg::SCORE_W-1:0]        score_sel
);
    import wpr_pkg::*;

    logic [SCORE_W-1:0] score_reg, score_next;
    logic [SCORE_W-1:0] nsc_reg, nsc_next;
    logic [OSUM_W-1:0]  osum_reg, osum_next;
    logic [OSUM_W-1:0]  rem_reg, rem_next;
    logic [SCORE_W-1:0] dlo_reg, dlo_next;
    logic [SCORE_W-1:0] term_reg, term_next;

    logic               is_me;
    logic               active;
    logic [OSUM_W:0]    osum_add;
    logic [OSUM_W:0]    trial;
    logic               ge;
    logic [WEIGHT_W+SCORE_W-1:0] prod;

    assign is_me  = (idx == IW'(CELL_ID));
    assign active = (CW'(CELL_ID) < n);

    always_comb
    begin
        score_next = score_reg;
        nsc_next   = nsc_reg;
        osum_next  = osum_reg;
        rem_next   = rem_reg;
        dlo_next   = dlo_reg;
        term_next  = term_reg;
        osum_add   = {1'b0, osum_reg} + (OSUM_W+1)'(lane_w);
        trial      = {rem_reg, dlo_reg[SCORE_W-1]};
        ge         = (trial >= {1'b0, osum_reg});
        prod       = lane_w * score_reg;
        unique case (ctrl.op)
            OP_INIT:
            begin
                score_next = ONE_Q816;
                osum_next  = '0;
            end
            OP_SUM:
            begin
                if (!is_me)
                begin
                    osum_next = (osum_add > (OSUM_W+1)'(OSUM_MAX)) ? OSUM_MAX
                                                                   : osum_add[OSUM_W-1:0];
                end
            end
            OP_MUL:
            begin
                rem_next = OSUM_W'(prod[WEIGHT_W+SCORE_W-1:SCORE_W]);
                dlo_next = prod[SCORE_W-1:0];
            end
            OP_DIV:
            begin
                rem_next = ge ? OSUM_W'(trial - {1'b0, osum_reg}) : trial[OSUM_W-1:0];
                dlo_next = {dlo_reg[SCORE_W-2:0], ge};
            end
            OP_LOADT:
            begin
                term_next = (active && !is_me && (osum_reg != '0)) ? dlo_reg : '0;
            end
            OP_SHIFT:
            begin
                term_next = prev_term;
            end
            OP_UPD:
            begin
                if (is_me)
                begin
                    nsc_next = ctrl.nv;
                end
            end
            OP_COMMIT:
            begin
                if (active)
                begin
                    score_next = nsc_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_reg <= ONE_Q816;
        end
        else
        begin
            score_reg <= score_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nsc_reg  <= nsc_next;
        osum_reg <= osum_next;
        rem_reg  <= rem_next;
        dlo_reg  <= dlo_next;
        term_reg <= term_next;
    end

    assign term      = term_reg;
    assign score_sel = is_me ? score_reg : '0;

endmodule

`default_nettype wire

[rtl/weighted_pagerank_iteration.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_pagerank_iteration
// Weighted PageRank power iteration over a loaded edge-weight matrix.
// ----------------------------------------------------------------------------
// Matrix elements transfer in one per cycle while the block is idle. The
// element flagged last starts the run: a setup step initialises the scores and
// out-sums, and a read and an accumulate per node sum the out-weights. Each
// iteration then runs, per node, a column read, a multiply, the 24-step divider
// in every cell, a shift of terms down the cell chain, a damping multiply and a
// score update. Scores then leave one per transfer, and a clearing pass over the
// weight memory follows; the same pass runs after reset. Input is not taken from
// the last element until the pass ends.
// ----------------------------------------------------------------------------
module weighted_pagerank_iteration #(
    parameter int MAX_NODES = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    wpr_in_if.sink                           in_ch,
    wpr_out_if.source                        out_ch,
    input  wire logic                        cfg_write,
    input  wire logic [wpr_pkg::CFGI_W-1:0]  cfg_index,
    input  wire logic [wpr_pkg::CFG_W-1:0]   cfg_data
);
    import wpr_pkg::*;

    localparam int IW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW    = $clog2(MAX_NODES + 1);
    localparam int AW    = SCORE_W + IW;
    localparam int PW    = 16 + AW;
    localparam int CNT_W = (IW > 5) ? IW : 5;

    wpr_state_t state_reg, state_next;

    logic [5:0]         ncount_reg;
    logic [15:0]        damp_reg;
    logic [15:0]        tol_reg;
    logic [7:0]         maxit_reg;

    logic [IW-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]         iter_reg, iter_next;
    logic               conv_reg, conv_next;
    logic [SCORE_W-1:0] maxd_reg, maxd_next;
    logic [AW-1:0]      acc_reg, acc_next;
    logic [PW-1:0]      prod_reg, prod_next;
    logic [CW-1:0]      n_reg, n_next;

    logic [NODE_W-1:0]  onode_reg, onode_next;
    logic [SCORE_W-1:0] oscore_reg, oscore_next;
    logic               oconv_reg, oconv_next;
    logic               olast_reg, olast_next;

    logic [CW-1:0]      n_cfg;
    logic               in_take;
    logic               in_range;
    logic               idx_last;
    logic [16:0]        base;
    logic [AW:0]        v;
    logic [SCORE_W-1:0] nv;
    logic [SCORE_W-1:0] old_score;
    logic [SCORE_W-1:0] diff;

    logic                          mem_we;
    logic                          mem_clear;
    logic [IW-1:0]                 mem_addr;
    logic [MAX_NODES*WEIGHT_W-1:0] mem_rd;

    cell_ctrl_t         ctrl;
    logic [SCORE_W-1:0] term_w  [MAX_NODES];
    logic [SCORE_W-1:0] ssel_w  [MAX_NODES];

    assign in_take  = in_ch.valid && in_ch.ready;
    assign in_range = (int'(in_ch.row_index) < MAX_NODES) &&
                      (int'(in_ch.col_index) < MAX_NODES);
    assign idx_last = ({1'b0, idx_reg} == (IW+1)'(n_reg - CW'(1)));

    always_comb
    begin
        if (int'(ncount_reg) < 2)
        begin
            n_cfg = CW'(2);
        end
        else if (int'(ncount_reg) > MAX_NODES)
        begin
            n_cfg = CW'(MAX_NODES);
        end
        else
        begin
            n_cfg = CW'(ncount_reg);
        end
    end

    always_comb
    begin
        old_score = '0;
        for (int k = 0; k < MAX_NODES; k++)
        begin
            old_score = old_score | ssel_w[k];
        end
    end

    assign base = 17'(ONE_Q816) - {1'b0, damp_reg};
    assign v    = (AW+1)'(base) + (AW+1)'(prod_reg >> 16);
    assign nv   = (v > (AW+1)'(SCORE_MAX)) ? SCORE_MAX : v[SCORE_W-1:0];
    assign diff = (nv > old_score) ? (nv - old_score) : (old_score - nv);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:      if (idx_reg == IW'(MAX_NODES - 1)) state_next = S_IDLE;
            S_IDLE:       if (in_take && in_ch.last) state_next = S_INIT;
            S_INIT:       state_next = S_SUM_RD;
            S_SUM_RD:     state_next = S_SUM_ACC;
            S_SUM_ACC:    if (idx_last) state_next = S_ITER_START;
                          else state_next = S_SUM_RD;
            S_ITER_START: if (iter_reg >= maxit_reg) state_next = S_OUT_LOAD;
                          else state_next = S_RD;
            S_RD:         state_next = S_MUL;
            S_MUL:        state_next = S_DIV;
            S_DIV:        if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = S_LOADT;
            S_LOADT:      state_next = S_SHIFT;
            S_SHIFT:      if (cnt_reg == CNT_W'(MAX_NODES - 1)) state_next = S_MULD;
            S_MULD:       state_next = S_UPD;
            S_UPD:        if (idx_last) state_next = S_ITER_END;
                          else state_next = S_RD;
            S_ITER_END:   if (maxd_reg < {8'd0, tol_reg}) state_next = S_OUT_LOAD;
                          else state_next = S_ITER_START;
            S_OUT_LOAD:   state_next = S_OUT_WAIT;
            S_OUT_WAIT:
            begin
                if (out_ch.ready)
                begin
                    state_next = idx_last ? S_CLEAR : S_OUT_LOAD;
                end
            end
            default:      state_next = S_CLEAR;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        iter_next   = iter_reg;
        conv_next   = conv_reg;
        maxd_next   = maxd_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        n_next      = n_reg;
        onode_next  = onode_reg;
        oscore_next = oscore_reg;
        oconv_next  = oconv_reg;
        olast_next  = olast_reg;
        ctrl.op     = OP_HOLD;
        ctrl.nv     = nv;
        mem_we      = 1'b0;
        mem_clear   = 1'b0;
        mem_addr    = idx_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_clear = 1'b1;
                idx_next  = (idx_reg == IW'(MAX_NODES - 1)) ? '0 : idx_reg + IW'(1);
            end
            S_IDLE:
            begin
                mem_we   = in_take && in_range;
                mem_addr = IW'(in_ch.col_index);
                n_next   = n_cfg;
                idx_next = '0;
            end
            S_INIT:
            begin
                ctrl.op   = OP_INIT;
                iter_next = '0;
                conv_next = 1'b0;
            end
            S_SUM_RD:
            begin
            end
            S_SUM_ACC:
            begin
                ctrl.op  = OP_SUM;
                idx_next = idx_last ? '0 : idx_reg + IW'(1);
            end
            S_ITER_START:
            begin
                maxd_next = '0;
                idx_next  = '0;
            end
            S_RD:
            begin
            end
            S_MUL:
            begin
                ctrl.op  = OP_MUL;
                cnt_next = '0;
            end
            S_DIV:
            begin
                ctrl.op  = OP_DIV;
                cnt_next = (cnt_reg == CNT_W'(DIV_STEPS - 1)) ? '0 : cnt_reg + CNT_W'(1);
            end
            S_LOADT:
            begin
                ctrl.op  = OP_LOADT;
                acc_next = '0;
                cnt_next = '0;
            end
            S_SHIFT:
            begin
                ctrl.op  = OP_SHIFT;
                acc_next = acc_reg + AW'(term_w[MAX_NODES-1]);
                cnt_next = cnt_reg + CNT_W'(1);
            end
            S_MULD:
            begin
                prod_next = damp_reg * acc_reg;
            end
            S_UPD:
            begin
                ctrl.op = OP_UPD;
                if (diff > maxd_reg)
                begin
                    maxd_next = diff;
                end
                idx_next = idx_last ? '0 : idx_reg + IW'(1);
            end
            S_ITER_END:
            begin
                ctrl.op   = OP_COMMIT;
                iter_next = iter_reg + 8'd1;
                conv_next = (maxd_reg < {8'd0, tol_reg});
                idx_next  = '0;
            end
            S_OUT_LOAD:
            begin
                onode_next  = NODE_W'(idx_reg);
                oscore_next = old_score;
                oconv_next  = conv_reg;
                olast_next  = idx_last;
            end
            S_OUT_WAIT:
            begin
                if (out_ch.ready)
                begin
                    idx_next = idx_last ? '0 : idx_reg + IW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            idx_reg    <= '0;
            cnt_reg    <= '0;
            iter_reg   <= '0;
            conv_reg   <= 1'b0;
            maxd_reg   <= '0;
            n_reg      <= CW'(2);
            ncount_reg <= 6'd32;
            damp_reg   <= 16'd55706;
            tol_reg    <= 16'd7;
            maxit_reg  <= 8'd100;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            iter_reg  <= iter_next;
            conv_reg  <= conv_next;
            maxd_reg  <= maxd_next;
            n_reg     <= n_next;
            if (cfg_write)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_NODE_COUNT: ncount_reg <= cfg_data[5:0];
                    CFG_DAMPING:    damp_reg   <= cfg_data;
                    CFG_TOLERANCE:  tol_reg    <= cfg_data;
                    CFG_MAX_ITER:   maxit_reg  <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        onode_reg  <= onode_next;
        oscore_reg <= oscore_next;
        oconv_reg  <= oconv_next;
        olast_reg  <= olast_next;
    end

    wpr_mem #(
        .MAX_NODES (MAX_NODES)
    ) u_mem (
        .clk      (clk),
        .wr_en    (mem_we),
        .wr_clear (mem_clear),
        .wr_addr  (mem_addr),
        .wr_lane  (IW'(in_ch.row_index)),
        .wr_data  (in_ch.weight),
        .rd_addr  (idx_reg),
        .rd_data  (mem_rd)
    );

    for (genvar k = 0; k < MAX_NODES; k++)
    begin : g_cell
        logic [SCORE_W-1:0] prev;
        if (k == 0)
        begin : g_head
            assign prev = '0;
        end
        else
        begin : g_body
            assign prev = term_w[k-1];
        end
        wpr_cell #(
            .MAX_NODES (MAX_NODES),
            .CELL_ID   (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .idx       (idx_reg),
            .n         (n_reg),
            .lane_w    (mem_rd[k*WEIGHT_W +: WEIGHT_W]),
            .prev_term (prev),
            .term      (term_w[k]),
            .score_sel (ssel_w[k])
        );
    end

    assign in_ch.ready        = (state_reg == S_IDLE);
    assign out_ch.valid       = (state_reg == S_OUT_WAIT);
    assign out_ch.node_index  = onode_reg;
    assign out_ch.score       = oscore_reg;
    assign out_ch.converged   = oconv_reg;
    assign out_ch.last_result = olast_reg;

endmodule

`default_nettype wire
